@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Implication checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

@@ rtl/rfr_pkg.sv @@
// ----------------------------------------------------------------------------
// rfr_pkg
// Types and constants of the routed frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none
package rfr_pkg;
    localparam int ROUTE_ENTRIES   = 16;
    localparam int SOURCE_TILES    = 64;
    localparam int MAX_FRAME_WORDS = 65536;
    localparam int ENTRY_W = 4;
    localparam int TILE_W  = 6;
    localparam logic [31:0] FRAME_MAGIC = 32'h474f4c4d;

    typedef enum logic [3:0] {
        ST_OK = 4'd0, ST_UNKNOWN = 4'd1, ST_BAD_MAGIC = 4'd2, ST_BAD_ROUTE = 4'd3,
        ST_EXEC = 4'd4, ST_LENGTH = 4'd5, ST_DUP = 4'd6, ST_ZERO = 4'd7,
        ST_FAILED = 4'd8
    } status_t;

    typedef enum logic [2:0] {
        PH_MAGIC = 3'd0, PH_ROUTE = 3'd1, PH_EXEC_LO = 3'd2, PH_EXEC_HI = 3'd3,
        PH_COUNT = 3'd4, PH_PAYLOAD = 3'd5
    } phase_t;

    typedef struct packed {
        logic                req_type;
        logic [TILE_W-1:0]   src_tile;
        logic [31:0]         payload;
        logic [ENTRY_W-1:0]  entry_index;
        logic                entry_valid;
        logic [31:0]         entry_rid;
        logic [TILE_W-1:0]   entry_source;
        logic [16:0]         entry_words;
        logic [7:0]          entry_slot;
    } in_item_t;

    typedef struct packed {
        logic [3:0]          status;
        logic                store_valid;
        logic [7:0]          store_slot;
        logic [15:0]         store_index;
        logic [31:0]         store_data;
        logic                route_done;
        logic [ENTRY_W-1:0]  done_entry;
        logic                all_received;
    } out_item_t;

    // Per-source parser entry kept in memory.
    typedef struct packed {
        logic [2:0]          phase;
        logic [31:0]         rid;
        logic [63:0]         exec_id;
        logic [ENTRY_W-1:0]  entry;
        logic [16:0]         total;
        logic [16:0]         count;
    } src_ent_t;
endpackage
`default_nettype wire

@@ rtl/rfr_src_mem.sv @@
// ----------------------------------------------------------------------------
// rfr_src_mem
// Per-source parser state memory, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module rfr_src_mem (
    input  wire                   clk,
    input  wire                   we,
    input  wire  [5:0]            waddr,
    input  wire rfr_pkg::src_ent_t wdata,
    input  wire  [5:0]            raddr,
    output rfr_pkg::src_ent_t     rdata
);
    import rfr_pkg::*;
    src_ent_t mem [SOURCE_TILES];
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/routed_frame_receiver_top.sv @@
// ----------------------------------------------------------------------------
// routed_frame_receiver_top
// Deframes routed words per source tile and emits payload stores.
// ----------------------------------------------------------------------------
// channel  | signals                      | dir
// in       | in_valid/in_ready/in_data    | request in
// out      | out_valid/out_ready/out_data | result out
// cfg      | cfg_we/cfg_wdata             | register write
// Each request first reads its source's parser entry from the source memory,
// then is checked, written back and loaded into the output register.
// A clearing pass after reset zeroes all 64 entries of the source memory;
// no request is taken until it ends. The output register holds a result until
// taken; a new request is read while it waits, but is finished only when
// the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none
module routed_frame_receiver_top (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire rfr_pkg::in_item_t in_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output rfr_pkg::out_item_t  out_data,
    input  wire                 cfg_we,
    input  wire  [63:0]         cfg_wdata
);
    import rfr_pkg::*;

    logic [63:0] exec_id_reg;
    logic [ROUTE_ENTRIES-1:0] tvalid_reg, recv_reg;
    logic [31:0] trid_reg [ROUTE_ENTRIES];
    logic [5:0]  tsrc_reg [ROUTE_ENTRIES];
    logic [16:0] twords_reg [ROUTE_ENTRIES];
    logic [7:0]  tslot_reg [ROUTE_ENTRIES];
    logic [3:0]  sticky_reg;

    logic        clr_reg;
    logic [6:0]  clr_cnt_reg;
    logic        busy_reg;      // request held, entry being read
    in_item_t    hold_reg;

    src_ent_t    rd_ent, wr_ent;
    logic        wr_en;
    logic [5:0]  wr_addr;
    logic [5:0]  rd_addr;

    logic        fin;
    out_item_t   res;
    src_ent_t    nxt;
    logic        known;
    logic        found;
    logic [3:0]  hit;

    assign in_ready = !clr_reg && !busy_reg;
    assign fin = busy_reg && (!out_valid || out_ready);

    // Keep reading the held request's tile while it waits for the output.
    assign rd_addr = busy_reg ? hold_reg.src_tile : in_data.src_tile;

    rfr_src_mem u_mem (
        .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_ent),
        .raddr(rd_addr), .rdata(rd_ent)
    );

    // Source known and route lookup over the table.
    always_comb
    begin
        known = 1'b0;
        found = 1'b0;
        hit   = '0;
        for (int e = ROUTE_ENTRIES-1; e >= 0; e--)
        begin
            if (tvalid_reg[e] && tsrc_reg[e] == hold_reg.src_tile)
                known = 1'b1;
            if (tvalid_reg[e] && trid_reg[e] == rd_ent.rid)
            begin
                found = 1'b1;
                hit   = e[3:0];
            end
        end
    end

    // Evaluate the held request.
    always_comb
    begin
        res = '0;
        nxt = rd_ent;
        wr_en = 1'b0;
        if (hold_reg.req_type)
            res.status = ST_OK;
        else if (sticky_reg != '0)
            res.status = ST_FAILED;
        else if (!known)
            res.status = ST_UNKNOWN;
        else
        begin
            wr_en = 1'b1;
            case (rd_ent.phase)
                PH_MAGIC:
                    if (hold_reg.payload != FRAME_MAGIC)
                    begin
                        res.status = ST_BAD_MAGIC;
                        wr_en = 1'b0;
                    end
                    else
                        nxt.phase = PH_ROUTE;
                PH_ROUTE:
                begin
                    nxt.rid = hold_reg.payload;
                    nxt.phase = PH_EXEC_LO;
                end
                PH_EXEC_LO:
                begin
                    nxt.exec_id = {32'd0, hold_reg.payload};
                    nxt.phase = PH_EXEC_HI;
                end
                PH_EXEC_HI:
                begin
                    nxt.exec_id[63:32] = hold_reg.payload;
                    nxt.phase = PH_COUNT;
                end
                PH_COUNT:
                begin
                    wr_en = 1'b0;
                    if (!found || tsrc_reg[hit] != hold_reg.src_tile)
                        res.status = ST_BAD_ROUTE;
                    else if (rd_ent.exec_id != exec_id_reg)
                        res.status = ST_EXEC;
                    else if ({15'd0, twords_reg[hit]} != hold_reg.payload
                             || hold_reg.payload > 32'(MAX_FRAME_WORDS))
                        res.status = ST_LENGTH;
                    else if (recv_reg[hit])
                        res.status = ST_DUP;
                    else if (hold_reg.payload == '0)
                        res.status = ST_ZERO;
                    else
                    begin
                        wr_en = 1'b1;
                        nxt.entry = hit;
                        nxt.total = hold_reg.payload[16:0];
                        nxt.count = '0;
                        nxt.phase = PH_PAYLOAD;
                    end
                end
                default:
                begin
                    res.store_valid = 1'b1;
                    res.store_slot  = tslot_reg[rd_ent.entry];
                    res.store_index = rd_ent.count[15:0];
                    res.store_data  = hold_reg.payload;
                    nxt.count = rd_ent.count + 17'd1;
                    if (nxt.count >= rd_ent.total)
                    begin
                        nxt.phase = PH_MAGIC;
                        res.route_done = 1'b1;
                        res.done_entry = rd_ent.entry;
                    end
                end
            endcase
        end
        wr_en = (wr_en && fin) || clr_reg;
    end

    assign wr_addr = clr_reg ? clr_cnt_reg[5:0] : hold_reg.src_tile;
    assign wr_ent  = clr_reg ? '0 : nxt;

    // Control, table and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_id_reg <= '0;
            tvalid_reg  <= '0;
            recv_reg    <= '0;
            sticky_reg  <= '0;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
            busy_reg    <= 1'b0;
            hold_reg    <= '0;
            out_valid   <= 1'b0;
            out_data    <= '0;
        end
        else
        begin
            if (cfg_we)
                exec_id_reg <= cfg_wdata;
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 7'd1;
                if (clr_cnt_reg == 7'(SOURCE_TILES - 1))
                    clr_reg <= 1'b0;
            end
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            if (in_valid && in_ready)
            begin
                busy_reg <= 1'b1;
                hold_reg <= in_data;
            end
            if (fin)
            begin
                logic [ROUTE_ENTRIES-1:0] tv, rv;
                out_item_t ov;
                tv = tvalid_reg;
                rv = recv_reg;
                ov = res;
                busy_reg  <= 1'b0;
                out_valid <= 1'b1;
                if (hold_reg.req_type)
                begin
                    tv[hold_reg.entry_index] = hold_reg.entry_valid;
                    rv[hold_reg.entry_index] = 1'b0;
                    trid_reg[hold_reg.entry_index]   <= hold_reg.entry_rid;
                    tsrc_reg[hold_reg.entry_index]   <= hold_reg.entry_source;
                    twords_reg[hold_reg.entry_index] <= hold_reg.entry_words;
                    tslot_reg[hold_reg.entry_index]  <= hold_reg.entry_slot;
                end
                if (res.route_done)
                    rv[res.done_entry] = 1'b1;
                if (res.status != ST_OK && res.status != ST_FAILED)
                    sticky_reg <= res.status;
                ov.all_received = ((tv & ~rv) == '0);
                tvalid_reg <= tv;
                recv_reg   <= rv;
                out_data   <= ov;
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/rfr_checker.sv @@
// ----------------------------------------------------------------------------
// rfr_checker
// Port-level checks of the routed frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module rfr_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 in_valid,
    input wire                 in_ready,
    input wire rfr_pkg::out_item_t out_data,
    input wire                 out_valid,
    input wire                 out_ready
);
    `CHK_IMPLY(a_store_zero, clk, rst_n, out_valid && !out_data.store_valid,
        out_data.store_index == '0 && out_data.store_data == '0)
    `CHK_IMPLY(a_done_store, clk, rst_n, out_valid && out_data.route_done, out_data.store_valid)
    `CHK_IMPLY(a_status_range, clk, rst_n, out_valid, out_data.status <= 4'd8)
    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    `CHK_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid)
endmodule
bind routed_frame_receiver_top rfr_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
);
`default_nettype wire

@@ tb/tb_rfr_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rfr_checker
// Watches the request, result and register ports of the routed frame
// receiver, predicts every result from its own copy of the parser and route
// table state, and compares the results field by field in order.
// ----------------------------------------------------------------------------
module tb_rfr_checker (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    input  wire                in_ready,
    input  rfr_pkg::in_item_t  in_data,
    input  wire                out_valid,
    input  wire                out_ready,
    input  rfr_pkg::out_item_t out_data,
    input  wire                cfg_we,
    input  wire  [63:0]        cfg_wdata,
    output int                 mismatches,
    output int                 awaited
);
    import rfr_pkg::*;

    logic [63:0] local_exec;
    phase_t      tile_phase [SOURCE_TILES];
    logic [31:0] tile_route [SOURCE_TILES];
    logic [63:0] tile_exec  [SOURCE_TILES];
    logic [3:0]  tile_entry [SOURCE_TILES];
    logic [16:0] tile_total [SOURCE_TILES];
    logic [16:0] tile_count [SOURCE_TILES];
    logic        rt_valid [ROUTE_ENTRIES];
    logic [31:0] rt_id    [ROUTE_ENTRIES];
    logic [5:0]  rt_src   [ROUTE_ENTRIES];
    logic [16:0] rt_words [ROUTE_ENTRIES];
    logic [7:0]  rt_slot  [ROUTE_ENTRIES];
    logic        rt_rcvd  [ROUTE_ENTRIES];
    status_t     first_error;
    out_item_t   result_q [$];

    initial begin
        mismatches = 0;
        awaited = 0;
        local_exec = '0;
        first_error = ST_OK;
        for (int t = 0; t < SOURCE_TILES; t++)
        begin
            tile_phase[t] = PH_MAGIC;
            tile_route[t] = '0;
            tile_exec[t]  = '0;
            tile_entry[t] = '0;
            tile_total[t] = '0;
            tile_count[t] = '0;
        end
        for (int e = 0; e < ROUTE_ENTRIES; e++)
        begin
            rt_valid[e] = 1'b0;
            rt_rcvd[e]  = 1'b0;
            rt_id[e] = '0;
            rt_src[e] = '0;
            rt_words[e] = '0;
            rt_slot[e] = '0;
        end
    end

    // Advance the parser and table state by one request; return its result.
    function automatic out_item_t deframe(in_item_t rq);
        out_item_t r;
        status_t   st;
        logic      known;
        logic      hit_ok;
        int        hit;
        int        t;
        r = '0;
        st = ST_OK;
        t = rq.src_tile;
        if (rq.req_type)
        begin
            rt_valid[rq.entry_index] = rq.entry_valid;
            rt_id[rq.entry_index]    = rq.entry_rid;
            rt_src[rq.entry_index]   = rq.entry_source;
            rt_words[rq.entry_index] = rq.entry_words;
            rt_slot[rq.entry_index]  = rq.entry_slot;
            rt_rcvd[rq.entry_index]  = 1'b0;
        end
        else if (first_error != ST_OK)
            st = ST_FAILED;
        else
        begin
            known = 1'b0;
            for (int e = 0; e < ROUTE_ENTRIES; e++)
                if (rt_valid[e] && rt_src[e] == rq.src_tile)
                    known = 1'b1;
            if (!known)
                st = ST_UNKNOWN;
            else
                case (tile_phase[t])
                    PH_MAGIC:
                        if (rq.payload != FRAME_MAGIC)
                            st = ST_BAD_MAGIC;
                        else
                            tile_phase[t] = PH_ROUTE;
                    PH_ROUTE:
                    begin
                        tile_route[t] = rq.payload;
                        tile_phase[t] = PH_EXEC_LO;
                    end
                    PH_EXEC_LO:
                    begin
                        tile_exec[t] = {32'h0, rq.payload};
                        tile_phase[t] = PH_EXEC_HI;
                    end
                    PH_EXEC_HI:
                    begin
                        tile_exec[t][63:32] = rq.payload;
                        tile_phase[t] = PH_COUNT;
                    end
                    PH_COUNT:
                    begin
                        hit_ok = 1'b0;
                        hit = 0;
                        for (int e = ROUTE_ENTRIES - 1; e >= 0; e--)
                            if (rt_valid[e] && rt_id[e] == tile_route[t])
                            begin
                                hit_ok = 1'b1;
                                hit = e;
                            end
                        if (!hit_ok || rt_src[hit] != rq.src_tile)
                            st = ST_BAD_ROUTE;
                        else if (tile_exec[t] != local_exec)
                            st = ST_EXEC;
                        else if ({15'h0, rt_words[hit]} != rq.payload
                                 || rq.payload > MAX_FRAME_WORDS)
                            st = ST_LENGTH;
                        else if (rt_rcvd[hit])
                            st = ST_DUP;
                        else if (rq.payload == 0)
                            st = ST_ZERO;
                        else
                        begin
                            tile_entry[t] = hit[3:0];
                            tile_total[t] = rq.payload[16:0];
                            tile_count[t] = '0;
                            tile_phase[t] = PH_PAYLOAD;
                        end
                    end
                    default:
                    begin
                        r.store_valid = 1'b1;
                        r.store_slot  = rt_slot[tile_entry[t]];
                        r.store_index = tile_count[t][15:0];
                        r.store_data  = rq.payload;
                        tile_count[t] = tile_count[t] + 1'b1;
                        if (tile_count[t] >= tile_total[t])
                        begin
                            rt_rcvd[tile_entry[t]] = 1'b1;
                            tile_phase[t] = PH_MAGIC;
                            r.route_done  = 1'b1;
                            r.done_entry  = tile_entry[t];
                        end
                    end
                endcase
            if (st != ST_OK)
                first_error = st;
        end
        r.status = st;
        r.all_received = 1'b1;
        for (int e = 0; e < ROUTE_ENTRIES; e++)
            if (rt_valid[e] && !rt_rcvd[e])
                r.all_received = 1'b0;
        return r;
    endfunction

    task automatic report(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (cfg_we)
                local_exec = cfg_wdata;
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, out_data);
                end
                else
                begin
                    want = result_q.pop_front();
                    report("status", want.status, out_data.status);
                    report("store_valid", want.store_valid, out_data.store_valid);
                    report("store_slot", want.store_slot, out_data.store_slot);
                    report("store_index", want.store_index, out_data.store_index);
                    report("store_data", want.store_data, out_data.store_data);
                    report("route_done", want.route_done, out_data.route_done);
                    report("done_entry", want.done_entry, out_data.done_entry);
                    report("all_received", want.all_received, out_data.all_received);
                end
            end
            if (in_valid && in_ready)
                result_q.push_back(deframe(in_data));
            awaited = result_q.size();
        end
    end
endmodule

@@ tb/tb_routed_frame_receiver_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_routed_frame_receiver_top
// Drives the routed frame receiver with route table writes and interleaved
// frames from several tiles under random sender and receiver stalls, changes
// the execution id between phases, and ends with one protocol violation that
// latches the sticky error. A checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb_routed_frame_receiver_top;
    import rfr_pkg::*;

    localparam int ITEM_TARGET = 1800;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int LANES = 4;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [63:0] cfg_wdata = '0;

    logic in_taken = 1'b0;
    logic out_taken = 1'b0;
    int mismatches;
    int awaited;
    int cycles = 0;

    // Stimulus-side shadow of the route table, used only to build frames.
    logic        sh_valid [ROUTE_ENTRIES];
    logic [31:0] sh_id    [ROUTE_ENTRIES];
    logic [5:0]  sh_src   [ROUTE_ENTRIES];
    logic [16:0] sh_words [ROUTE_ENTRIES];
    logic [63:0] exec_id = '0;
    in_item_t    lane_q [LANES][$];

    int  requests_sent = 0;
    int  frames_built = 0;
    int  cfg_writes = 0;
    int  error_class = 0;
    bit  tx_eager = 1'b0;
    bit  rx_eager = 1'b0;
    bit  hold_req = 1'b0;

    routed_frame_receiver_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    tb_rfr_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .mismatches(mismatches), .awaited(awaited)
    );

    always #5 clk = ~clk;

    // Record each handshake at the edge so the falling-edge drivers see it.
    always @(posedge clk)
    begin
        in_taken  <= in_valid && in_ready;
        out_taken <= out_valid && out_ready;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_routed_frame_receiver_top: done, errors");
            $finish;
        end
    end

    // Result side: random stall per result, stretches of none, one long hold-off.
    initial
    begin
        int w;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            w = rx_eager ? 0 : $urandom_range(0, 15);
            if (w > 0)
            begin
                out_ready = 1'b0;
                repeat (w) @(negedge clk);
            end
            out_ready = 1'b1;
            while (!out_taken)
                @(negedge clk);
        end
    end

    // Fill a request with random bits so unused fields toggle too.
    function automatic in_item_t noise_item();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return raw[$bits(in_item_t)-1:0];
    endfunction

    function automatic in_item_t routed_word(logic [5:0] tile, logic [31:0] word);
        in_item_t it;
        it = noise_item();
        it.req_type = 1'b0;
        it.src_tile = tile;
        it.payload = word;
        return it;
    endfunction

    // Offer one request after a random gap; hold it until taken.
    task automatic send(in_item_t it);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data = it;
        in_valid = 1'b1;
        do
            @(negedge clk);
        while (!in_taken);
        requests_sent++;
    endtask

    task automatic write_route(int e, logic v, logic [31:0] id, logic [5:0] src,
                               logic [16:0] words, logic [7:0] slot);
        in_item_t it;
        it = noise_item();
        it.req_type = 1'b1;
        it.entry_index = e[3:0];
        it.entry_valid = v;
        it.entry_rid = id;
        it.entry_source = src;
        it.entry_words = words;
        it.entry_slot = slot;
        sh_valid[e] = v;
        sh_id[e] = id;
        sh_src[e] = src;
        sh_words[e] = words;
        send(it);
    endtask

    // Queue magic, route id, exec id halves and count on a lane.
    task automatic queue_header(int lane, logic [5:0] tile, logic [31:0] id,
                                logic [63:0] ex, logic [31:0] count);
        lane_q[lane].push_back(routed_word(tile, FRAME_MAGIC));
        lane_q[lane].push_back(routed_word(tile, id));
        lane_q[lane].push_back(routed_word(tile, ex[31:0]));
        lane_q[lane].push_back(routed_word(tile, ex[63:32]));
        lane_q[lane].push_back(routed_word(tile, count));
    endtask

    task automatic queue_frame(int lane, int e);
        queue_header(lane, sh_src[e], sh_id[e], exec_id, {15'h0, sh_words[e]});
        for (int i = 0; i < sh_words[e]; i++)
            lane_q[lane].push_back(routed_word(sh_src[e], $urandom));
        frames_built++;
    endtask

    // Interleave the lanes word by word in random order until all are empty.
    task automatic drain_lanes();
        int lane;
        int left;
        forever
        begin
            left = 0;
            for (int l = 0; l < LANES; l++)
                left += lane_q[l].size();
            if (left == 0)
                break;
            do
                lane = $urandom_range(0, LANES - 1);
            while (lane_q[lane].size() == 0);
            send(lane_q[lane].pop_front());
        end
    endtask

    // Drop valid, wait for every result, then write the execution id.
    task automatic set_exec(logic [63:0] v);
        in_valid = 1'b0;
        while (awaited != 0 || out_valid)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
        exec_id = v;
        cfg_writes++;
    endtask

    function automatic logic [16:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 17'($urandom_range(1, 6));
        else if (r < 96)
            return 17'($urandom_range(7, 40));
        return 17'($urandom_range(100, 300));
    endfunction

    initial
    begin
        int n;
        int rounds;
        int pick [LANES];
        logic [5:0] tiles [LANES];
        bit clash;
        int le;
        logic [5:0] lt;
        logic [5:0] stray;
        bit taken_tile;

        for (int e = 0; e < ROUTE_ENTRIES; e++)
            sh_valid[e] = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed: smallest and largest tile, slot, id and data; exec id extremes.
        tx_eager = 1'b1;
        write_route(0, 1'b1, 32'h0000_0000, 6'd0, 17'd1, 8'd0);
        queue_frame(0, 0);
        lane_q[0][5].payload = 32'h0000_0000;
        drain_lanes();
        set_exec(64'hFFFF_FFFF_FFFF_FFFF);
        write_route(15, 1'b1, 32'hFFFF_FFFF, 6'd63, 17'd2, 8'd255);
        queue_frame(0, 15);
        lane_q[0][5].payload = 32'hFFFF_FFFF;
        drain_lanes();
        // Redefine a route while its frame is in flight: payload follows the new slot.
        write_route(1, 1'b1, 32'h5A5A_0001, 6'd33, 17'd2, 8'd17);
        queue_frame(0, 1);
        for (int i = 0; i < 6; i++)
            send(lane_q[0].pop_front());
        write_route(1, 1'b1, 32'h5A5A_0001, 6'd33, 17'd2, 8'd170);
        drain_lanes();
        // An unused entry: all_received ignores it.
        write_route(7, 1'b0, 32'h1234_5677, 6'd12, 17'h1FFFF, 8'h81);
        set_exec(64'h0);
        tx_eager = 1'b0;

        // Random rounds of interleaved frames from distinct tiles.
        rounds = 0;
        le = 0;
        lt = '0;
        while (requests_sent < ITEM_TARGET)
        begin
            rounds++;
            tx_eager = ($urandom_range(0, 3) == 0);
            rx_eager = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) == 0)
                case ($urandom_range(0, 2))
                    0: set_exec(64'h0);
                    1: set_exec(64'hFFFF_FFFF_FFFF_FFFF);
                    default: set_exec({$urandom, $urandom});
                endcase
            if (rounds == 12)
                hold_req = 1'b1;
            n = $urandom_range(1, LANES);
            for (int l = 0; l < n; l++)
            begin
                do
                begin
                    pick[l] = $urandom_range(0, ROUTE_ENTRIES - 1);
                    tiles[l] = 6'($urandom_range(0, SOURCE_TILES - 1));
                    clash = 1'b0;
                    for (int k = 0; k < l; k++)
                        if (pick[k] == pick[l] || tiles[k] == tiles[l])
                            clash = 1'b1;
                end
                while (clash);
                // Route ids carry the entry number in the low nibble to stay unique.
                write_route(pick[l], 1'b1,
                            {28'($urandom_range(0, 32'h0FFF_FFFF)), 4'(pick[l])},
                            tiles[l], pick_length(), 8'($urandom_range(0, 255)));
                queue_frame(l, pick[l]);
            end
            // Table noise on an entry no lane is using.
            if ($urandom_range(0, 2) == 0)
            begin
                do
                begin
                    le = $urandom_range(0, ROUTE_ENTRIES - 1);
                    clash = 1'b0;
                    for (int k = 0; k < n; k++)
                        if (pick[k] == le)
                            clash = 1'b1;
                end
                while (clash);
                write_route(le, 1'($urandom_range(0, 1)),
                            {28'($urandom_range(0, 32'h0FFF_FFFF)), 4'(le)},
                            6'($urandom_range(0, 63)), 17'($urandom_range(0, 17'h1FFFF)),
                            8'($urandom_range(0, 255)));
            end
            drain_lanes();
            le = pick[0];
            lt = tiles[0];
        end

        // Tail: one protocol violation, then words refused and a table write taken.
        set_exec(exec_id);
        tx_eager = 1'b0;
        error_class = $urandom_range(1, 7);
        case (error_class)
            1:
            begin
                do
                begin
                    stray = 6'($urandom_range(0, 63));
                    taken_tile = 1'b0;
                    for (int e = 0; e < ROUTE_ENTRIES; e++)
                        if (sh_valid[e] && sh_src[e] == stray)
                            taken_tile = 1'b1;
                end
                while (taken_tile);
                send(routed_word(stray, FRAME_MAGIC));
            end
            2: send(routed_word(lt, ~FRAME_MAGIC));
            3:
            begin
                write_route(le ^ 1, 1'b0, 32'h0, 6'd0, 17'd1, 8'd0);
                queue_header(0, lt, {28'($urandom_range(0, 32'h0FFF_FFFF)), 4'(le ^ 1)},
                             exec_id, 32'd1);
            end
            4: queue_header(0, lt, sh_id[le], ~exec_id, {15'h0, sh_words[le]});
            5:
                if ($urandom_range(0, 1))
                begin
                    write_route(le, 1'b1, sh_id[le], lt, 17'h1FFFF, 8'd9);
                    queue_header(0, lt, sh_id[le], exec_id, 32'h1FFFF);
                end
                else
                begin
                    write_route(le, 1'b1, sh_id[le], lt, 17'd3, 8'd9);
                    queue_header(0, lt, sh_id[le], exec_id, 32'd4);
                end
            6: queue_header(0, lt, sh_id[le], exec_id, {15'h0, sh_words[le]});
            default:
            begin
                write_route(le, 1'b1, sh_id[le], lt, 17'd0, 8'd9);
                queue_header(0, lt, sh_id[le], exec_id, 32'd0);
            end
        endcase
        drain_lanes();
        send(routed_word(lt, FRAME_MAGIC));
        write_route(le, 1'b1, sh_id[le], lt, 17'd1, 8'd1);
        send(routed_word(lt, $urandom));
        in_valid = 1'b0;

        // Wait for the last results, then let the pipeline settle.
        while (awaited != 0 || out_valid)
            @(negedge clk);
        repeat (8) @(negedge clk);
        $display("Sent %0d requests in %0d frames with %0d exec id writes;",
                 requests_sent, frames_built, cfg_writes);
        $display("run ended on sticky error class %0d, %0d mismatches.",
                 error_class, mismatches);
        if (mismatches == 0)
            $display("tb_routed_frame_receiver_top: done, clean");
        else
            $display("tb_routed_frame_receiver_top: done, errors");
        $finish;
    end
endmodule

@@ routed_frame_receiver_top.f @@
+incdir+rtl
rtl/rfr_pkg.sv
rtl/rfr_src_mem.sv
rtl/routed_frame_receiver_top.sv
rtl/rfr_checker.sv
tb/tb_rfr_checker.sv
tb/tb_routed_frame_receiver_top.sv
